// ===== hw/rtl/plin_pkg.sv =====
// Shared constants and status codes for the piecewise linear interpolator.
package plin_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int STEP_W = $clog2(PROD_W + 1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== hw/rtl/plin_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module plin_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/plin_div.sv =====
// Restoring divider: 64-bit unsigned dividend by 32-bit divisor, one bit per cycle.
module plin_div
    import plin_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);
    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [PROD_W-1:0] r_num;
    logic [DATA_W-1:0] r_den;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quot;

    logic [DATA_W:0]   n_trial;
    logic              n_ge;
    logic [DATA_W:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_num[PROD_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num  <= {r_num[PROD_W-2:0], 1'b0};
                r_rem  <= n_ge ? n_diff[DATA_W-1:0] : n_trial[DATA_W-1:0];
                r_quot <= {r_quot[DATA_W-2:0], n_ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== hw/rtl/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator: sorted breakpoint table and query logic.
//
//  Channel | Dir | Handshake              | Payload
//  --------+-----+------------------------+------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tdata: x_value[31:0], y_value[63:32];
//          |     |                        | tuser: op[0]
//  m       | out | o_m_tvalid/i_m_tready  | tdata: result_value[31:0]; tuser: status[1:0]
//
// One item is worked on at a time. An add runs S binary-search steps (at most clog2(N+1)),
// then reads the stored entry at the found position if there is one, and then moves every
// stored entry above the new point up one place before the result register loads.
// An in-range query searches, reads both segment ends, then waits on the bit-serial divider.
// The shared breakpoint RAM, with one read port and registered read data, paces
// the search and the shift. Reset is synchronous and clears the point count; the
// table contents need no clearing. A result waits in the output register while the
// next item is already taken in; a stalled output blocks only the end of the next item.
module piecewise_linear_interpolator
    import plin_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // x_value [31:0], y_value [63:32]
    input  logic [0:0]  i_s_tuser,   // op [0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // result_value [31:0]
    output logic [1:0]  o_m_tuser    // status [1:0]
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCH_W, S_CHK_W, S_SHF, S_SHF_W,
        S_K0, S_K0_W, S_K1_W, S_MUL, S_DIVGO, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic   [CW-1:0] r_count;
    logic   [CW-1:0] r_lo, r_hi, r_pos, r_i, r_k;
    logic   r_op;
    logic   signed [DATA_W-1:0] r_x, r_y;
    logic   signed [DATA_W-1:0] r_xk, r_yk;
    logic   [DATA_W-1:0] r_dx, r_den, r_absdy;
    logic   r_neg;
    logic   [PROD_W-1:0] r_prod;
    logic   [DATA_W-1:0] r_res;
    logic   [1:0] r_st;
    logic   r_m_valid;
    logic   [DATA_W-1:0] r_m_data;
    logic   [1:0] r_m_st;

    // Breakpoint RAM: each entry holds {y, x}.
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [PROD_W-1:0] w_wdata, w_rdata;
    logic signed [DATA_W-1:0] w_rx, w_ry;

    logic [CW:0]     w_sum;
    logic [CW-1:0]   w_mid;
    logic [CW-1:0]   w_kc;
    logic [DATA_W:0] w_dx, w_den, w_dy, w_ady;
    logic            w_div_done;
    logic [DATA_W-1:0] w_quot;
    logic            w_accept;

    assign w_rx     = w_rdata[DATA_W-1:0];
    assign w_ry     = w_rdata[PROD_W-1:DATA_W];
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[CW:1];
    assign w_accept = i_s_tvalid && o_s_tready;

    assign w_dx  = {r_x[DATA_W-1], r_x} - {r_xk[DATA_W-1], r_xk};
    assign w_den = {w_rx[DATA_W-1], w_rx} - {r_xk[DATA_W-1], r_xk};
    assign w_dy  = {w_ry[DATA_W-1], w_ry} - {r_yk[DATA_W-1], r_yk};
    assign w_ady = w_dy[DATA_W] ? (~w_dy + 1'b1) : w_dy;

    // Segment index after the equality check, capped at the last segment.
    always_comb begin
        w_kc = (w_rx == r_x) ? r_pos : (r_pos - 1'b1);
        if (w_kc > (r_count - CW'(2))) begin
            w_kc = r_count - CW'(2);
        end
    end

    // RAM port control.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[AW-1:0];
        w_wdata = {r_y, r_x};
        w_raddr = r_k[AW-1:0];
        case (r_state)
            S_SRCH: begin
                w_raddr = (r_lo < r_hi) ? w_mid[AW-1:0] : r_lo[AW-1:0];
            end
            S_CHK_W: begin
                w_we = (r_op == OP_ADD) && (w_rx == r_x);
            end
            S_SHF: begin
                w_raddr = AW'(r_i - 1'b1);
                w_we    = (r_i <= r_pos);
            end
            S_SHF_W: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = w_rdata;
            end
            S_K0_W: begin
                w_raddr = AW'(r_k + 1'b1);
            end
            default: begin
            end
        endcase
    end

    plin_ram #(
        .WIDTH (PROD_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    plin_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // The output register empties here unless a new result loads it below.
            if (r_m_valid && i_m_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= i_s_tuser[0];
                        r_x   <= i_s_tdata[DATA_W-1:0];
                        r_y   <= i_s_tdata[PROD_W-1:DATA_W];
                        r_lo  <= '0;
                        r_hi  <= r_count;
                        r_res <= '0;
                        if ((i_s_tuser[0] == OP_QUERY) && (r_count < CW'(2))) begin
                            r_st    <= ST_RANGE;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    // Binary search for the number of points with x below the key.
                    if (r_lo < r_hi) begin
                        r_state <= S_SRCH_W;
                    end else begin
                        r_pos <= r_lo;
                        r_i   <= r_count;
                        if (r_lo < r_count) begin
                            r_state <= S_CHK_W;
                        end else if (r_op == OP_QUERY) begin
                            r_st    <= ST_RANGE;
                            r_state <= S_OUT;
                        end else if (r_count == CW'(MAX_POINTS)) begin
                            r_st    <= ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SHF;
                        end
                    end
                end
                S_SRCH_W: begin
                    if (w_rx < r_x) begin
                        r_lo <= w_mid + 1'b1;
                    end else begin
                        r_hi <= w_mid;
                    end
                    r_state <= S_SRCH;
                end
                S_CHK_W: begin
                    if (r_op == OP_ADD) begin
                        if (w_rx == r_x) begin
                            // Repeated x: the y was replaced in place.
                            r_st    <= ST_OK;
                            r_state <= S_OUT;
                        end else if (r_count == CW'(MAX_POINTS)) begin
                            r_st    <= ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SHF;
                        end
                    end else if ((w_rx != r_x) && (r_pos == '0)) begin
                        r_st    <= ST_RANGE;
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= w_kc;
                        r_state <= S_K0;
                    end
                end
                S_SHF: begin
                    if (r_i > r_pos) begin
                        r_state <= S_SHF_W;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_st    <= ST_OK;
                        r_state <= S_OUT;
                    end
                end
                S_SHF_W: begin
                    r_i     <= r_i - 1'b1;
                    r_state <= S_SHF;
                end
                S_K0: begin
                    r_state <= S_K0_W;
                end
                S_K0_W: begin
                    r_xk    <= w_rx;
                    r_yk    <= w_ry;
                    r_state <= S_K1_W;
                end
                S_K1_W: begin
                    r_dx    <= w_dx[DATA_W-1:0];
                    r_den   <= w_den[DATA_W-1:0];
                    r_absdy <= w_ady[DATA_W-1:0];
                    r_neg   <= w_dy[DATA_W];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_absdy) * PROD_W'(r_dx);
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= r_neg ? (r_yk - w_quot) : (r_yk + w_quot);
                        r_st    <= ST_OK;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_res;
                        r_m_st    <= r_st;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_st;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count above table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |-> r_count == $past(r_count) + 1'b1)
        else $error("point count moved by other than one");

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_OK) |-> o_m_tdata == '0)
        else $error("nonzero result with error status");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_FULL) |-> r_count == CW'(MAX_POINTS))
        else $error("full status while table has room");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside its wait state");
`endif
endmodule
